// ----- rtl/core/cnms_pkg.sv -----
// shared types, constants and helper functions of the canny suppression block
`default_nettype none

package cnms_pkg;

    // field widths fixed by the external interface
    localparam int MAG_W      = 11;
    localparam int ANGLE_W    = 11;
    localparam int ROW_W      = 13;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int CLASS_W    = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int THR_W      = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    // compare width for the clamped row length, holds the largest buffer depth
    localparam int WCMP_W     = 14;

    // result queue between the window stage and the output side
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;
    localparam int MAX_PUSH   = 2;

    // configuration reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THR_W-1:0]    LOW_RESET    = 11'd115;
    localparam logic [THR_W-1:0]    HIGH_RESET   = 11'd361;

    // angle bounds in quarter degrees
    localparam logic [ANGLE_W-1:0] ANGLE_HALF_TURN = 11'd720;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL_TURN = 11'd1440;
    localparam logic [ANGLE_W-1:0] ANGLE_B0        = 11'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_B1        = 11'd270;
    localparam logic [ANGLE_W-1:0] ANGLE_B2        = 11'd450;
    localparam logic [ANGLE_W-1:0] ANGLE_B3        = 11'd630;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_LOW_THRESHOLD  = 2'd2,
        REG_HIGH_THRESHOLD = 2'd3
    } cnms_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } cnms_op_t;

    typedef enum logic [1:0] {
        SEC_0   = 2'd0,
        SEC_45  = 2'd1,
        SEC_90  = 2'd2,
        SEC_135 = 2'd3
    } cnms_sector_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE   = 2'd0,
        CLASS_WEAK   = 2'd1,
        CLASS_STRONG = 2'd2
    } cnms_class_t;

    // control flags of the item held between the front and the window stage
    typedef struct packed {
        logic valid;
        logic drain;
        logic emit_first;
        logic emit_second;
        logic top;
        logic left_first;
        logic left_second;
    } cnms_ctrl_t;

    typedef struct packed {
        logic [MAG_W-1:0] top;
        logic [MAG_W-1:0] mid;
        logic [MAG_W-1:0] bot;
    } cnms_column_t;

    typedef struct packed {
        logic [MAG_W-1:0] kept;
        cnms_class_t      cls;
    } cnms_verdict_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] column;
        logic [MAG_W-1:0]     kept;
        cnms_class_t          cls;
        logic                 last;
    } cnms_result_t;

    // fold the direction into half a turn and pick one of four sectors
    function automatic cnms_sector_t quantize(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0] a;
        cnms_sector_t       s;
        if (angle >= ANGLE_FULL_TURN)
        begin
            a = angle - ANGLE_FULL_TURN;
        end
        else if (angle >= ANGLE_HALF_TURN)
        begin
            a = angle - ANGLE_HALF_TURN;
        end
        else
        begin
            a = angle;
        end
        priority if (a <= ANGLE_B0)
        begin
            s = SEC_0;
        end
        else if (a <= ANGLE_B1)
        begin
            s = SEC_45;
        end
        else if (a <= ANGLE_B2)
        begin
            s = SEC_90;
        end
        else if (a <= ANGLE_B3)
        begin
            s = SEC_135;
        end
        else
        begin
            s = SEC_0;
        end
        return s;
    endfunction

    // suppress against the two neighbours along the sector, then class
    function automatic cnms_verdict_t judge(
        input cnms_column_t     lcol,
        input cnms_column_t     ccol,
        input cnms_column_t     rcol,
        input cnms_sector_t     sector,
        input logic             top,
        input logic             bottom,
        input logic             left,
        input logic             right,
        input logic [THR_W-1:0] low_thr,
        input logic [THR_W-1:0] high_thr
    );
        logic [MAG_W-1:0] p;
        logic [MAG_W-1:0] n1;
        logic [MAG_W-1:0] n2;
        logic             ok1;
        logic             ok2;
        cnms_verdict_t    v;
        p = ccol.mid;
        unique case (sector)
            SEC_0:
            begin
                n1 = lcol.mid;  ok1 = left;
                n2 = rcol.mid;  ok2 = right;
            end
            SEC_45:
            begin
                n1 = rcol.bot;  ok1 = right && bottom;
                n2 = lcol.top;  ok2 = left && top;
            end
            SEC_90:
            begin
                n1 = ccol.top;  ok1 = top;
                n2 = ccol.bot;  ok2 = bottom;
            end
            SEC_135:
            begin
                n1 = lcol.bot;  ok1 = left && bottom;
                n2 = rcol.top;  ok2 = right && top;
            end
            default:
            begin
                n1 = '0;  ok1 = 1'b0;
                n2 = '0;  ok2 = 1'b0;
            end
        endcase
        if ((ok1 && (p < n1)) || (ok2 && (p < n2)))
        begin
            v.kept = '0;
        end
        else
        begin
            v.kept = p;
        end
        priority if ((v.kept == '0) || (v.kept < low_thr))
        begin
            v.cls = CLASS_NONE;
        end
        else if (v.kept > high_thr)
        begin
            v.cls = CLASS_STRONG;
        end
        else
        begin
            v.cls = CLASS_WEAK;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cnms_if.sv -----
// valid/ready channel interfaces for gradient pixels and edge results
`default_nettype none

interface cnms_pixel_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [cnms_pkg::MAG_W-1:0]         magnitude;
    logic [cnms_pkg::ANGLE_W-1:0]       angle_quarter_deg;

    modport source (output valid, output operation, output magnitude,
                    output angle_quarter_deg, input ready);
    modport sink   (input valid, input operation, input magnitude,
                    input angle_quarter_deg, output ready);
endinterface

interface cnms_result_if;
    logic                               valid;
    logic                               ready;
    logic [cnms_pkg::ROW_OUT_W-1:0]     out_row;
    logic [cnms_pkg::COL_OUT_W-1:0]     out_column;
    logic [cnms_pkg::MAG_W-1:0]         kept_magnitude;
    logic [cnms_pkg::CLASS_W-1:0]       edge_class;
    logic                               last_of_frame;

    modport source (output valid, output out_row, output out_column,
                    output kept_magnitude, output edge_class,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_row, input out_column,
                    input kept_magnitude, input edge_class,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cnms_front.sv -----
// front end: raster counters, drain detection, sector quantization, line buffer read
`default_nettype none

module cnms_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_W     = 11,
    parameter int COL_W     = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic                              operation,
    input  wire logic [cnms_pkg::MAG_W-1:0]        magnitude,
    input  wire logic [cnms_pkg::ANGLE_W-1:0]      angle_quarter_deg,
    input  wire logic [cnms_pkg::WIDTH_W-1:0]      image_width,
    input  wire logic [cnms_pkg::HEIGHT_W-1:0]     image_height,
    output logic                                   rd_en,
    output logic [COL_W-1:0]                       rd_addr,
    output cnms_pkg::cnms_ctrl_t                   ctrl,
    output logic [COL_W-1:0]                       item_col,
    output logic [cnms_pkg::ROW_OUT_W-1:0]         item_row,
    output logic [MAG_W-1:0]                       item_mag,
    output cnms_pkg::cnms_sector_t                 item_sector
);

    localparam int CW = cnms_pkg::WCMP_W;
    localparam int RW = cnms_pkg::ROW_W;

    logic [COL_W-1:0]           col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    cnms_pkg::cnms_ctrl_t       ctrl_reg, ctrl_next;
    logic [COL_W-1:0]           col_out_reg;
    logic [cnms_pkg::ROW_OUT_W-1:0] row_out_reg;
    logic [MAG_W-1:0]           mag_reg;
    cnms_pkg::cnms_sector_t     sector_reg;

    logic [CW-1:0]              width_eff;
    logic [RW-1:0]              height_eff;
    logic                       drain;
    logic                       ignored;
    logic                       last_col;
    logic [RW-1:0]              row_m1;

    always_comb
    begin
        priority if (image_width == '0)
        begin
            width_eff = CW'(1);
        end
        else if (CW'(image_width) > CW'(MAX_WIDTH))
        begin
            width_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CW'(image_width);
        end
        height_eff = (image_height == '0) ? RW'(1) : image_height;
        drain      = row_reg >= height_eff;
        // a drain request before the last row is complete is dropped
        ignored    = !drain && (operation == cnms_pkg::OP_DRAIN);
        last_col   = (CW'(col_reg) + CW'(1)) >= width_eff;
        row_m1     = row_reg - RW'(1);
    end

    assign rd_en   = accept && !ignored;
    assign rd_addr = col_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (rd_en)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = drain ? '0 : (row_reg + RW'(1));
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        ctrl_next.valid       = rd_en;
        ctrl_next.drain       = drain;
        ctrl_next.emit_first  = (row_reg != '0) && (col_reg != '0);
        ctrl_next.emit_second = (row_reg != '0) && last_col;
        ctrl_next.top         = row_reg >= RW'(2);
        ctrl_next.left_first  = col_reg >= COL_W'(2);
        ctrl_next.left_second = col_reg != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ctrl_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            col_out_reg <= col_reg;
            row_out_reg <= row_m1[cnms_pkg::ROW_OUT_W-1:0];
            mag_reg     <= drain ? '0 : magnitude[MAG_W-1:0];
            sector_reg  <= cnms_pkg::quantize(angle_quarter_deg);
        end
    end

    assign ctrl        = ctrl_reg;
    assign item_col    = col_out_reg;
    assign item_row    = row_out_reg;
    assign item_mag    = mag_reg;
    assign item_sector = sector_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cnms_window.sv -----
// line buffer memory, 3x3 window and suppression of up to two pixels per item
`default_nettype none

module cnms_window #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_W     = 11,
    parameter int COL_W     = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [COL_W-1:0]                  rd_addr,
    input  wire cnms_pkg::cnms_ctrl_t              ctrl,
    input  wire logic [COL_W-1:0]                  item_col,
    input  wire logic [cnms_pkg::ROW_OUT_W-1:0]    item_row,
    input  wire logic [MAG_W-1:0]                  item_mag,
    input  wire cnms_pkg::cnms_sector_t            item_sector,
    input  wire logic [cnms_pkg::THR_W-1:0]        low_threshold,
    input  wire logic [cnms_pkg::THR_W-1:0]        high_threshold,
    output logic                                   push_first,
    output logic                                   push_second,
    output cnms_pkg::cnms_result_t                 res_first,
    output cnms_pkg::cnms_result_t                 res_second
);

    localparam int MW     = cnms_pkg::MAG_W;
    localparam int WORD_W = 2 * MAG_W + 2;
    localparam int CEXT_W = COL_W + cnms_pkg::COL_OUT_W;

    // word: older row magnitude, previous row magnitude, previous row sector
    logic [WORD_W-1:0]          line_mem [MAX_WIDTH];
    logic [WORD_W-1:0]          rd_data_reg;
    logic                       byp_reg;
    logic [WORD_W-1:0]          byp_word_reg;

    logic                       wr_en;
    logic [WORD_W-1:0]          wr_word;
    logic [WORD_W-1:0]          word;
    logic [MAG_W-1:0]           older_mag;
    logic [MAG_W-1:0]           prev_mag;
    cnms_pkg::cnms_sector_t     prev_sector;

    cnms_pkg::cnms_column_t     col_a_reg, col_a_next;
    cnms_pkg::cnms_column_t     col_b_reg, col_b_next;
    cnms_pkg::cnms_sector_t     sec_b_reg, sec_b_next;
    cnms_pkg::cnms_column_t     col_new;

    cnms_pkg::cnms_verdict_t    verdict_first;
    cnms_pkg::cnms_verdict_t    verdict_second;
    logic [COL_W-1:0]           col_m1;
    logic [CEXT_W-1:0]          col_ext_first;
    logic [CEXT_W-1:0]          col_ext_second;

    assign wr_en = ctrl.valid && !ctrl.drain;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[item_col] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg  <= line_mem[rd_addr];
            byp_word_reg <= wr_word;
        end
    end

    // same column read while it is being written, only with one-pixel rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (item_col == rd_addr);
        end
    end

    always_comb
    begin
        word        = byp_reg ? byp_word_reg : rd_data_reg;
        older_mag   = word[WORD_W-1 -: MAG_W];
        prev_mag    = word[MAG_W+1 -: MAG_W];
        prev_sector = cnms_pkg::cnms_sector_t'(word[1:0]);
        wr_word     = {prev_mag, item_mag, item_sector};
        col_new.top = MW'(older_mag);
        col_new.mid = MW'(prev_mag);
        col_new.bot = MW'(item_mag);
    end

    always_comb
    begin
        col_a_next = col_a_reg;
        col_b_next = col_b_reg;
        sec_b_next = sec_b_reg;
        if (ctrl.valid)
        begin
            col_a_next = col_b_reg;
            col_b_next = col_new;
            sec_b_next = prev_sector;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_a_reg <= '0;
            col_b_reg <= '0;
            sec_b_reg <= cnms_pkg::SEC_0;
        end
        else
        begin
            col_a_reg <= col_a_next;
            col_b_reg <= col_b_next;
            sec_b_reg <= sec_b_next;
        end
    end

    always_comb
    begin
        verdict_first  = cnms_pkg::judge(col_a_reg, col_b_reg, col_new, sec_b_reg,
                                         ctrl.top, !ctrl.drain, ctrl.left_first, 1'b1,
                                         low_threshold, high_threshold);
        // right neighbour lies outside the image for the last column
        verdict_second = cnms_pkg::judge(col_b_reg, col_new, col_new, prev_sector,
                                         ctrl.top, !ctrl.drain, ctrl.left_second, 1'b0,
                                         low_threshold, high_threshold);
        col_m1         = item_col - COL_W'(1);
        col_ext_first  = CEXT_W'(col_m1);
        col_ext_second = CEXT_W'(item_col);

        res_first.row     = item_row;
        res_first.column  = col_ext_first[cnms_pkg::COL_OUT_W-1:0];
        res_first.kept    = verdict_first.kept;
        res_first.cls     = verdict_first.cls;
        res_first.last    = 1'b0;

        res_second.row    = item_row;
        res_second.column = col_ext_second[cnms_pkg::COL_OUT_W-1:0];
        res_second.kept   = verdict_second.kept;
        res_second.cls    = verdict_second.cls;
        res_second.last   = ctrl.drain;
    end

    assign push_first  = ctrl.valid && ctrl.emit_first;
    assign push_second = ctrl.valid && ctrl.emit_second;

endmodule

`default_nettype wire

// ----- rtl/core/cnms_fifo.sv -----
// result queue taking up to two results a cycle and feeding the output channel
`default_nettype none

module cnms_fifo (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push_first,
    input  wire logic                     push_second,
    input  wire cnms_pkg::cnms_result_t   res_first,
    input  wire cnms_pkg::cnms_result_t   res_second,
    output logic                          room,
    cnms_result_if.source                 result
);

    localparam int PW = cnms_pkg::FIFO_PTR_W;
    localparam int NW = cnms_pkg::FIFO_CNT_W;

    cnms_pkg::cnms_result_t     entry_reg [cnms_pkg::FIFO_DEPTH];
    logic [PW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]              count_reg, count_next;

    cnms_pkg::cnms_result_t     slot0;
    logic [1:0]                 n_push;
    logic                       pop;
    cnms_pkg::cnms_result_t     head;

    always_comb
    begin
        slot0       = push_first ? res_first : res_second;
        n_push      = 2'(push_first) + 2'(push_second);
        pop         = result.valid && result.ready;
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + NW'(n_push) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= slot0;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= res_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // leave space for the item in the window stage and the one being taken
    assign room = count_reg <= NW'(cnms_pkg::FIFO_DEPTH - 2 * cnms_pkg::MAX_PUSH);

    assign head                  = entry_reg[rd_ptr_reg];
    assign result.valid          = count_reg != '0;
    assign result.out_row        = head.row;
    assign result.out_column     = head.column;
    assign result.kept_magnitude = head.kept;
    assign result.edge_class     = head.cls;
    assign result.last_of_frame  = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/canny_nonmax_suppress_threshold.sv -----
// top level: canny non-maximum suppression with double threshold on a pixel stream
//
//   channel   dir   handshake          payload
//   pixel     in    valid / ready      operation, magnitude, angle_quarter_deg
//   result    out   valid / ready      out_row, out_column, kept_magnitude,
//                                      edge_class, last_of_frame
//   config    in    write_enable       write_index, write_data
//
// one pixel per cycle while the result queue has room; a result is registered in the front stage and the queue
// a request yields one result, none at the start of a row or on the first row, two at its end
// the last row is flushed by image_width drain requests after the frame
// ready drops while the eight-entry result queue holds more than four results
// async reset clears counters, window and queue; line buffer contents start undefined
`default_nettype none

module canny_nonmax_suppress_threshold #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_BITS  = 11
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    cnms_pixel_if.sink                               pixel,
    cnms_result_if.source                            result,
    input  wire logic                                write_enable,
    input  wire logic [cnms_pkg::CFG_IDX_W-1:0]      write_index,
    input  wire logic [cnms_pkg::CFG_DATA_W-1:0]     write_data
);

    localparam int MB    = (MAG_BITS < cnms_pkg::MAG_W) ? MAG_BITS : cnms_pkg::MAG_W;
    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [cnms_pkg::WIDTH_W-1:0]   image_width_reg;
    logic [cnms_pkg::HEIGHT_W-1:0]  image_height_reg;
    logic [cnms_pkg::THR_W-1:0]     low_threshold_reg;
    logic [cnms_pkg::THR_W-1:0]     high_threshold_reg;

    logic                           accept;
    logic                           room;
    logic                           rd_en;
    logic [COL_W-1:0]               rd_addr;
    cnms_pkg::cnms_ctrl_t           ctrl;
    logic [COL_W-1:0]               item_col;
    logic [cnms_pkg::ROW_OUT_W-1:0] item_row;
    logic [MB-1:0]                  item_mag;
    cnms_pkg::cnms_sector_t         item_sector;
    logic                           push_first;
    logic                           push_second;
    cnms_pkg::cnms_result_t         res_first;
    cnms_pkg::cnms_result_t         res_second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= cnms_pkg::WIDTH_RESET;
            image_height_reg   <= cnms_pkg::HEIGHT_RESET;
            low_threshold_reg  <= cnms_pkg::LOW_RESET;
            high_threshold_reg <= cnms_pkg::HIGH_RESET;
        end
        else if (write_enable)
        begin
            unique case (cnms_pkg::cnms_reg_t'(write_index))
                cnms_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= write_data[cnms_pkg::WIDTH_W-1:0];
                end
                cnms_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= write_data[cnms_pkg::HEIGHT_W-1:0];
                end
                cnms_pkg::REG_LOW_THRESHOLD:
                begin
                    low_threshold_reg <= write_data[cnms_pkg::THR_W-1:0];
                end
                cnms_pkg::REG_HIGH_THRESHOLD:
                begin
                    high_threshold_reg <= write_data[cnms_pkg::THR_W-1:0];
                end
                default:
                begin
                    image_width_reg <= image_width_reg;
                end
            endcase
        end
    end

    assign pixel.ready = room;
    assign accept      = pixel.valid && room;

    cnms_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_W     (MB),
        .COL_W     (COL_W)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .operation         (pixel.operation),
        .magnitude         (pixel.magnitude),
        .angle_quarter_deg (pixel.angle_quarter_deg),
        .image_width       (image_width_reg),
        .image_height      (image_height_reg),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .ctrl              (ctrl),
        .item_col          (item_col),
        .item_row          (item_row),
        .item_mag          (item_mag),
        .item_sector       (item_sector)
    );

    cnms_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_W     (MB),
        .COL_W     (COL_W)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .ctrl           (ctrl),
        .item_col       (item_col),
        .item_row       (item_row),
        .item_mag       (item_mag),
        .item_sector    (item_sector),
        .low_threshold  (low_threshold_reg),
        .high_threshold (high_threshold_reg),
        .push_first     (push_first),
        .push_second    (push_second),
        .res_first      (res_first),
        .res_second     (res_second)
    );

    cnms_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_first  (push_first),
        .push_second (push_second),
        .res_first   (res_first),
        .res_second  (res_second),
        .room        (room),
        .result      (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/cnms_checker.sv -----
// port-level checks on the canny suppression block and their binding
`default_nettype none

module cnms_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              pixel_valid,
    input wire logic                              pixel_ready,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [cnms_pkg::ROW_OUT_W-1:0]    out_row,
    input wire logic [cnms_pkg::COL_OUT_W-1:0]    out_column,
    input wire logic [cnms_pkg::MAG_W-1:0]        kept_magnitude,
    input wire logic [cnms_pkg::CLASS_W-1:0]      edge_class,
    input wire logic                              last_of_frame
);

    // a waiting result keeps its content until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_row) &&
            $stable(out_column) && $stable(kept_magnitude) &&
            $stable(edge_class) && $stable(last_of_frame))
        else $error("result changed while stalled");

    // a suppressed pixel is never an edge
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kept_magnitude == '0) |-> edge_class == cnms_pkg::CLASS_NONE)
        else $error("zero magnitude classed as edge");

    // backpressure on pixels only comes from pending results
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> result_valid)
        else $error("pixel request stalled with no result pending");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result offered right after reset");

    // only a pixel request can start work, so no result without earlier input
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid, 2) || $past(pixel_valid, 3) ||
            $past(result_valid))
        else $error("result appeared without pixel request");

endmodule

bind canny_nonmax_suppress_threshold cnms_checker u_cnms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pixel_valid    (pixel.valid),
    .pixel_ready    (pixel.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .out_row        (result.out_row),
    .out_column     (result.out_column),
    .kept_magnitude (result.kept_magnitude),
    .edge_class     (result.edge_class),
    .last_of_frame  (result.last_of_frame)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the canny non-maximum suppression and double threshold block
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 16;
    localparam int BUF_DEPTH     = 1024;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_STALL    = 400;
    localparam int MAG_MAX       = 2047;
    localparam int ANGLE_MAX     = 2047;

    class edge_scoreboard;
        logic [cnms_pkg::WIDTH_W-1:0]  width_reg;
        logic [cnms_pkg::HEIGHT_W-1:0] height_reg;
        logic [cnms_pkg::THR_W-1:0]    low_reg;
        logic [cnms_pkg::THR_W-1:0]    high_reg;
        logic [cnms_pkg::MAG_W-1:0]    older_mag [BUF_DEPTH];
        logic [cnms_pkg::MAG_W-1:0]    prev_mag [BUF_DEPTH];
        cnms_pkg::cnms_sector_t        prev_sec [BUF_DEPTH];
        logic [cnms_pkg::MAG_W-1:0]    win [9];       // [column * 3 + position], position 0 top
        cnms_pkg::cnms_sector_t        win_sec [3];
        int unsigned                   col_ctr;
        int unsigned                   row_ctr;
        cnms_pkg::cnms_result_t        pending_verdicts [$];
        int unsigned                   frames;
        int unsigned                   taken;
        int unsigned                   ignored;
        int unsigned                   checked;
        int unsigned                   suppressed;
        int unsigned                   n_weak;
        int unsigned                   n_strong;
        int unsigned                   failures;

        function new();
            width_reg  = cnms_pkg::WIDTH_RESET;
            height_reg = cnms_pkg::HEIGHT_RESET;
            low_reg    = cnms_pkg::LOW_RESET;
            high_reg   = cnms_pkg::HIGH_RESET;
            foreach (older_mag[i])
            begin
                older_mag[i] = '0;
                prev_mag[i]  = '0;
                prev_sec[i]  = cnms_pkg::SEC_0;
            end
            foreach (win[i])
            begin
                win[i] = '0;
            end
            foreach (win_sec[i])
            begin
                win_sec[i] = cnms_pkg::SEC_0;
            end
            col_ctr    = 0;
            row_ctr    = 0;
            frames     = 0;
            taken      = 0;
            ignored    = 0;
            checked    = 0;
            suppressed = 0;
            n_weak     = 0;
            n_strong   = 0;
            failures   = 0;
        endfunction

        function void set_reg(cnms_pkg::cnms_reg_t idx, logic [cnms_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                cnms_pkg::REG_IMAGE_WIDTH:    width_reg  = val[cnms_pkg::WIDTH_W-1:0];
                cnms_pkg::REG_IMAGE_HEIGHT:   height_reg = val[cnms_pkg::HEIGHT_W-1:0];
                cnms_pkg::REG_LOW_THRESHOLD:  low_reg    = val[cnms_pkg::THR_W-1:0];
                cnms_pkg::REG_HIGH_THRESHOLD: high_reg   = val[cnms_pkg::THR_W-1:0];
                default:                      ;
            endcase
        endfunction

        function int unsigned used_width();
            if (width_reg < 1)
            begin
                return 1;
            end
            if (width_reg > BUF_DEPTH)
            begin
                return BUF_DEPTH;
            end
            return width_reg;
        endfunction

        function int unsigned used_height();
            return (height_reg < 1) ? 1 : height_reg;
        endfunction

        function bit draining();
            return row_ctr >= used_height();
        endfunction

        // direction folded into half a turn
        function cnms_pkg::cnms_sector_t sector_of(logic [cnms_pkg::ANGLE_W-1:0] ang);
            int unsigned a;
            a = ang % cnms_pkg::ANGLE_HALF_TURN;
            if (a <= cnms_pkg::ANGLE_B0)
            begin
                return cnms_pkg::SEC_0;
            end
            if (a <= cnms_pkg::ANGLE_B1)
            begin
                return cnms_pkg::SEC_45;
            end
            if (a <= cnms_pkg::ANGLE_B2)
            begin
                return cnms_pkg::SEC_90;
            end
            if (a <= cnms_pkg::ANGLE_B3)
            begin
                return cnms_pkg::SEC_135;
            end
            return cnms_pkg::SEC_0;
        endfunction

        function bit outranked(bit ok, logic [cnms_pkg::MAG_W-1:0] p, int idx);
            if (!ok)
            begin
                return 1'b0;
            end
            return p < win[idx];
        endfunction

        function cnms_pkg::cnms_result_t verdict(int wc, int unsigned row, int unsigned col,
                                                 bit top, bit bottom, bit left, bit right,
                                                 bit last);
            logic [cnms_pkg::MAG_W-1:0] p;
            bit                         beaten;
            cnms_pkg::cnms_result_t     v;
            int                         lc;
            int                         cc;
            int                         rc;
            p  = win[wc * 3 + 1];
            lc = (wc - 1) * 3;
            cc = wc * 3;
            rc = (wc + 1) * 3;
            case (win_sec[wc])
                cnms_pkg::SEC_0:   beaten = outranked(left, p, lc + 1)
                                            || outranked(right, p, rc + 1);
                cnms_pkg::SEC_45:  beaten = outranked(right && bottom, p, rc + 2)
                                            || outranked(left && top, p, lc);
                cnms_pkg::SEC_90:  beaten = outranked(top, p, cc)
                                            || outranked(bottom, p, cc + 2);
                cnms_pkg::SEC_135: beaten = outranked(left && bottom, p, lc + 2)
                                            || outranked(right && top, p, rc);
                default:           beaten = 1'b0;
            endcase
            v.row    = row[cnms_pkg::ROW_OUT_W-1:0];
            v.column = col[cnms_pkg::COL_OUT_W-1:0];
            v.kept   = beaten ? '0 : p;
            v.last   = last;
            if (beaten && p != 0)
            begin
                suppressed++;
            end
            if (v.kept == 0 || v.kept < low_reg)
            begin
                v.cls = cnms_pkg::CLASS_NONE;
            end
            else if (v.kept > high_reg)
            begin
                v.cls = cnms_pkg::CLASS_STRONG;
                n_strong++;
            end
            else
            begin
                v.cls = cnms_pkg::CLASS_WEAK;
                n_weak++;
            end
            return v;
        endfunction

        function void note_pixel(cnms_pkg::cnms_op_t op, logic [cnms_pkg::MAG_W-1:0] mag,
                                 logic [cnms_pkg::ANGLE_W-1:0] ang);
            int unsigned c;
            int unsigned r;
            int unsigned w;
            bit          drain;
            bit          last_col;
            bit          top;
            bit          bottom;
            w = used_width();
            c = col_ctr;
            r = row_ctr;
            if (c >= BUF_DEPTH)
            begin
                c = BUF_DEPTH - 1;
            end
            drain = draining();
            // a drain request before the last row is done has no effect
            if (!drain && op == cnms_pkg::OP_DRAIN)
            begin
                ignored++;
                return;
            end
            taken++;
            for (int k = 0; k < 6; k++)
            begin
                win[k] = win[k + 3];
            end
            win_sec[0] = win_sec[1];
            win_sec[1] = win_sec[2];
            win[6]     = older_mag[c];
            win[7]     = prev_mag[c];
            win[8]     = drain ? '0 : mag;
            win_sec[2] = prev_sec[c];
            if (!drain)
            begin
                older_mag[c] = prev_mag[c];
                prev_mag[c]  = mag;
                prev_sec[c]  = sector_of(ang);
            end
            last_col = (c + 1 >= w);
            if (r >= 1)
            begin
                top    = (r >= 2);
                bottom = !drain;
                if (c >= 1)
                begin
                    pending_verdicts.push_back(verdict(1, r - 1, c - 1, top, bottom, c >= 2,
                                                       1'b1, 1'b0));
                end
                if (last_col)
                begin
                    pending_verdicts.push_back(verdict(2, r - 1, c, top, bottom, c >= 1,
                                                       1'b0, drain));
                end
            end
            if (last_col)
            begin
                col_ctr = 0;
                if (drain)
                begin
                    row_ctr = 0;
                    frames++;
                end
                else
                begin
                    row_ctr = (r + 1) & 32'h1FFF;
                end
            end
            else
            begin
                col_ctr = c + 1;
            end
        endfunction

        function void check_result(cnms_pkg::cnms_result_t got);
            cnms_pkg::cnms_result_t want;
            bit                     bad;
            checked++;
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("unexpected result: row %0d col %0d kept %0d class %0d last %0d",
                             got.row, got.column, got.kept, got.cls, got.last);
                end
                return;
            end
            want = pending_verdicts.pop_front();
            bad  = (got.row !== want.row) || (got.column !== want.column)
                   || (got.kept !== want.kept) || (got.cls !== want.cls)
                   || (got.last !== want.last);
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected row %0d col %0d kept %0d class %0d last %0d",
                             want.row, want.column, want.kept, want.cls, want.last);
                    $display("          actual   row %0d col %0d kept %0d class %0d last %0d",
                             got.row, got.column, got.kept, got.cls, got.last);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            write_enable;
    logic [cnms_pkg::CFG_IDX_W-1:0]  write_index;
    logic [cnms_pkg::CFG_DATA_W-1:0] write_data;

    cnms_pixel_if  pix ();
    cnms_result_if res ();

    canny_nonmax_suppress_threshold DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pix),
        .result       (res),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    edge_scoreboard         sb;
    cnms_pkg::cnms_result_t seen_result;
    bit                     idle_on;
    int                     stall_req;
    int unsigned            random_items;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            sb.note_pixel(cnms_pkg::cnms_op_t'(pix.operation), pix.magnitude,
                          pix.angle_quarter_deg);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            seen_result.row    = res.out_row;
            seen_result.column = res.out_column;
            seen_result.kept   = res.kept_magnitude;
            seen_result.cls    = cnms_pkg::cnms_class_t'(res.edge_class);
            seen_result.last   = res.last_of_frame;
            sb.check_result(seen_result);
        end
    end

    // result side: random back-pressure plus an occasional long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req > 0)
            begin
                stall_left = stall_req;
                stall_req  = 0;
            end
            if (!rst_n)
            begin
                res.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                res.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready = idle_on ? ($urandom_range(99) >= 37) : 1'b1;
            end
        end
    end

    task automatic push_item(input cnms_pkg::cnms_op_t op,
                             input logic [cnms_pkg::MAG_W-1:0] mag,
                             input logic [cnms_pkg::ANGLE_W-1:0] ang);
        while (idle_on && $urandom_range(99) < 37)
        begin
            pix.valid = 1'b0;
            @(negedge clk);
        end
        pix.valid             = 1'b1;
        pix.operation         = op;
        pix.magnitude         = mag;
        pix.angle_quarter_deg = ang;
        do
        begin
            @(posedge clk);
        end
        while (!pix.ready);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result drain out
    task automatic wait_quiet();
        pix.valid = 1'b0;
        while (sb.pending_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cnms_pkg::cnms_reg_t idx, input int unsigned val);
        write_enable = 1'b1;
        write_index  = idx;
        write_data   = val[cnms_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, val[cnms_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
        write_enable = 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned lo, input int unsigned hi);
        wait_quiet();
        write_reg(cnms_pkg::REG_IMAGE_WIDTH, w);
        write_reg(cnms_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(cnms_pkg::REG_LOW_THRESHOLD, lo);
        write_reg(cnms_pkg::REG_HIGH_THRESHOLD, hi);
    endtask

    function automatic logic [cnms_pkg::MAG_W-1:0] pick_magnitude();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            return '0;
        end
        if (sel < 16)
        begin
            return cnms_pkg::MAG_W'(MAG_MAX);
        end
        // a narrow band gives plenty of ties between neighbours
        if (sel < 40)
        begin
            return cnms_pkg::MAG_W'($urandom_range(503, 500));
        end
        return cnms_pkg::MAG_W'($urandom_range(MAG_MAX));
    endfunction

    // mid-frame register change; width and height only shrink so no row reads stale lines
    task automatic change_geometry();
        int unsigned w;
        int unsigned sel;
        wait_quiet();
        w   = sb.used_width();
        sel = $urandom_range(2);
        if (sel == 1 && w > 3)
        begin
            write_reg(cnms_pkg::REG_IMAGE_WIDTH, $urandom_range(w - 1, 3));
        end
        else if (sel == 2 && sb.row_ctr >= 1 && !sb.draining())
        begin
            write_reg(cnms_pkg::REG_IMAGE_HEIGHT, $urandom_range(sb.row_ctr, 1));
        end
        else if ($urandom_range(1))
        begin
            write_reg(cnms_pkg::REG_LOW_THRESHOLD, $urandom_range(MAG_MAX));
        end
        else
        begin
            write_reg(cnms_pkg::REG_HIGH_THRESHOLD, $urandom_range(MAG_MAX));
        end
    endtask

    task automatic run_frame(input int change_at, input int stall_len);
        int unsigned        start_frames;
        int                 sent;
        cnms_pkg::cnms_op_t op;
        bit                 counts;
        start_frames = sb.frames;
        sent         = 0;
        while (sb.frames == start_frames)
        begin
            if (sent == change_at)
            begin
                change_geometry();
                change_at = -1;
            end
            if (stall_len > 0 && sb.row_ctr >= 1)
            begin
                stall_req = stall_len;
                stall_len = 0;
            end
            // pixel requests in the flush row act as drains, early drains are noise
            if (sb.draining())
            begin
                op = ($urandom_range(99) < 20) ? cnms_pkg::OP_PIXEL : cnms_pkg::OP_DRAIN;
            end
            else
            begin
                op = ($urandom_range(99) < 3) ? cnms_pkg::OP_DRAIN : cnms_pkg::OP_PIXEL;
            end
            counts = (op == cnms_pkg::OP_PIXEL) || sb.draining();
            push_item(op, pick_magnitude(), cnms_pkg::ANGLE_W'($urandom_range(ANGLE_MAX)));
            if (counts)
            begin
                sent++;
                random_items++;
            end
        end
        pix.valid = 1'b0;
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned lo;
        int unsigned hi;
        int          change_at;
        sb                    = new();
        idle_on               = 1'b1;
        stall_req             = 0;
        random_items          = 0;
        rst_n                 = 1'b0;
        write_enable          = 1'b0;
        write_index           = cnms_pkg::REG_IMAGE_WIDTH;
        write_data            = '0;
        pix.valid             = 1'b0;
        pix.operation         = cnms_pkg::OP_PIXEL;
        pix.magnitude         = '0;
        pix.angle_quarter_deg = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sector boundaries, magnitude extremes, early drain, pixel request in flush row
        set_frame(3, 3, 100, 1000);
        push_item(cnms_pkg::OP_PIXEL, 11'd500, 11'd0);
        push_item(cnms_pkg::OP_PIXEL, 11'd2047, 11'd90);
        push_item(cnms_pkg::OP_PIXEL, 11'd0, 11'd91);
        push_item(cnms_pkg::OP_DRAIN, 11'd7, 11'd7);
        push_item(cnms_pkg::OP_PIXEL, 11'd600, 11'd270);
        push_item(cnms_pkg::OP_PIXEL, 11'd700, 11'd271);
        push_item(cnms_pkg::OP_PIXEL, 11'd600, 11'd450);
        push_item(cnms_pkg::OP_PIXEL, 11'd300, 11'd451);
        push_item(cnms_pkg::OP_PIXEL, 11'd800, 11'd630);
        push_item(cnms_pkg::OP_PIXEL, 11'd300, 11'd631);
        push_item(cnms_pkg::OP_DRAIN, 11'd0, 11'd0);
        push_item(cnms_pkg::OP_PIXEL, 11'd1234, 11'd5);
        push_item(cnms_pkg::OP_DRAIN, 11'd0, 11'd0);

        // low above high, ties against thresholds, angles past half and full turn
        set_frame(4, 2, 500, 200);
        push_item(cnms_pkg::OP_PIXEL, 11'd500, 11'd719);
        push_item(cnms_pkg::OP_PIXEL, 11'd200, 11'd720);
        push_item(cnms_pkg::OP_PIXEL, 11'd500, 11'd1439);
        push_item(cnms_pkg::OP_PIXEL, 11'd2047, 11'd2047);
        push_item(cnms_pkg::OP_PIXEL, 11'd499, 11'd810);
        push_item(cnms_pkg::OP_PIXEL, 11'd500, 11'd811);
        push_item(cnms_pkg::OP_PIXEL, 11'd501, 11'd1350);
        push_item(cnms_pkg::OP_PIXEL, 11'd0, 11'd1351);
        repeat (4) push_item(cnms_pkg::OP_DRAIN, 11'd0, 11'd0);

        // a long row and a tall frame; the tall one runs without idling
        set_frame(256, 1, 0, MAG_MAX);
        run_frame(-1, 0);
        set_frame(3, 150, MAG_MAX, 0);
        idle_on = 1'b0;
        run_frame(-1, LONG_STALL);
        idle_on = 1'b1;

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            w = ($urandom_range(99) < 70) ? $urandom_range(10, 3)
              : ($urandom_range(99) < 85) ? $urandom_range(40, 11) : $urandom_range(200, 41);
            h = ($urandom_range(99) < 70) ? $urandom_range(4, 1) : $urandom_range(10, 5);
            if ($urandom_range(99) < 80)
            begin
                lo = $urandom_range(1200);
                hi = $urandom_range(MAG_MAX, lo);
            end
            else
            begin
                lo = $urandom_range(MAG_MAX);
                hi = $urandom_range(MAG_MAX);
            end
            change_at = ($urandom_range(99) < 12) ? int'($urandom_range(w * h - 1)) : -1;
            set_frame(w, h, lo, hi);
            run_frame(change_at, 0);
        end

        wait_quiet();
        $display("covered %0d frames, %0d requests taken, %0d early drains ignored",
                 sb.frames, sb.taken, sb.ignored);
        $display("checked %0d results: %0d suppressed, %0d weak, %0d strong, %0d failures",
                 sb.checked, sb.suppressed, sb.n_weak, sb.n_strong, sb.failures);
        if (sb.failures == 0 && sb.pending_verdicts.size() == 0)
        begin
            $display("canny_nonmax_suppress_threshold test passed");
        end
        else
        begin
            $display("canny_nonmax_suppress_threshold test failed");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.pending_verdicts.size());
        $display("canny_nonmax_suppress_threshold test failed");
        $finish;
    end

endmodule
